>>> rtl/slot_handle_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Slot handle allocator assertion macros
// Concurrent assertion helpers sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLOT_HANDLE_ALLOCATOR_TOP_MACROS_SVH
`define SLOT_HANDLE_ALLOCATOR_TOP_MACROS_SVH

// Check a condition on every clock edge outside reset
`define SHA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a consequent follows an antecedent after a fixed cycle count
`define SHA_ASSERT_LAT(label, ante, cyc, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##cyc (cons)) else $error(msg);

`endif

>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// Slot handle allocator package
// Transaction types, command and status codes, and default sizes.
// ----------------------------------------------------------------------------
package sha_pkg;

    // Default sizes
    localparam int DEF_SLOT_COUNT = 64;
    localparam int DEF_GEN_BITS   = 24;
    localparam int SLOT_FIELD_W   = 6;
    localparam int HANDLE_W       = 30;

    // Command codes
    localparam logic [1:0] CMD_ALLOC    = 2'd0;
    localparam logic [1:0] CMD_FREE     = 2'd1;
    localparam logic [1:0] CMD_VALIDATE = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOFREE  = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // Request transaction
    typedef struct packed {
        logic [1:0]              cmd;
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [HANDLE_W-1:0]     handle_in;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [1:0]              status;
        logic [SLOT_FIELD_W-1:0] slot_out;
        logic [HANDLE_W-1:0]     handle_out;
    } rsp_t;

    // Free map update request
    typedef struct packed {
        logic                    alloc_en;
        logic                    free_en;
        logic [SLOT_FIELD_W-1:0] free_slot;
    } fm_upd_t;

    // Lowest free slot
    typedef struct packed {
        logic                    any_free;
        logic [SLOT_FIELD_W-1:0] slot;
    } fm_pick_t;

endpackage

>>> rtl/sha_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sha_free_map.sv
// ----------------------------------------------------------------------------
// Slot handle allocator free map
// Holds the free bit of every slot, finds the lowest free slot and answers
// in-use lookups.
// ----------------------------------------------------------------------------
module sha_free_map #(
    parameter int SLOT_COUNT = sha_pkg::DEF_SLOT_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sha_pkg::fm_upd_t                    upd,
    output sha_pkg::fm_pick_t                   pick,
    input  logic [sha_pkg::SLOT_FIELD_W-1:0]    look_slot,
    output logic                                look_used
);

    import sha_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);

    logic [SLOT_COUNT-1:0] free_map_reg;
    logic [SLOT_COUNT-1:0] free_map_next;
    logic [SLOT_COUNT-1:0] lowest;
    logic [SLOT_W-1:0]     pick_slot;

    // Isolate the lowest set bit and encode its position
    always_comb
    begin
        lowest    = free_map_reg & (~free_map_reg + SLOT_COUNT'(1));
        pick_slot = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (lowest[i])
            begin
                pick_slot = pick_slot | SLOT_W'(i);
            end
        end
    end

    assign pick.any_free = |free_map_reg;
    assign pick.slot     = SLOT_FIELD_W'(pick_slot);

    // Claim the picked slot or release the requested one
    always_comb
    begin
        free_map_next = free_map_reg;
        if (upd.alloc_en)
        begin
            free_map_next[pick_slot] = 1'b0;
        end
        if (upd.free_en)
        begin
            free_map_next[upd.free_slot[SLOT_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg <= '1;
        end
        else
        begin
            free_map_reg <= free_map_next;
        end
    end

    assign look_used = ~free_map_reg[look_slot[SLOT_W-1:0]];

endmodule

>>> rtl/slot_handle_allocator_top.sv
// A transaction accepted at one edge shows its result (done high) after the
// input register, the free map / generation RAM read stage and the result register.
// Throughput: one transaction per cycle; busy is always low, the generation
// RAM's registered read port sets the extra stage.
// Reset: all slots free, all generations read as zero (per-slot valid bits),
// no clearing pass; results cannot be stalled.
// ----------------------------------------------------------------------------
// Slot handle allocator top level
// Allocates the lowest free slot with a wrapping generation count, frees
// slots and validates handles.
// ----------------------------------------------------------------------------
`include "slot_handle_allocator_top_macros.svh"

module slot_handle_allocator_top #(
    parameter int SLOT_COUNT = sha_pkg::DEF_SLOT_COUNT,
    parameter int GEN_BITS   = sha_pkg::DEF_GEN_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sha_pkg::req_t req,
    output logic          done,
    output sha_pkg::rsp_t rsp
);

    import sha_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    // Reciprocal for handle modulo slot count: exact for 30-bit handles
    localparam int K      = HANDLE_W + SLOT_W;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << K) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
    localparam int RCP_W  = HANDLE_W + 1;
    localparam int PRD_W  = HANDLE_W + RCP_W;
    localparam int Q_W    = PRD_W - K;
    localparam int RW     = HANDLE_W + SLOT_FIELD_W + 1;
    localparam int HP_W   = GEN_BITS + HANDLE_W;
    localparam logic [RCP_W-1:0] RECIP = RECIP_WIDE[RCP_W-1:0];

    // Stage 1 registers
    logic                    s1_vld_reg;
    req_t                    s1_req_reg;

    // Stage 2 registers
    logic                    s2_vld_reg;
    logic [1:0]              s2_cmd_reg;
    logic [SLOT_FIELD_W-1:0] s2_slot_reg;
    logic                    s2_ok_reg;
    logic [Q_W-1:0]          s2_quot_reg;
    logic [HANDLE_W-1:0]     s2_hin_reg;
    logic                    s2_gvld_reg;

    // Result registers
    logic                    done_reg;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;

    // Generation valid bits
    logic [SLOT_COUNT-1:0]   gen_vld_reg;

    logic                    accept;
    fm_upd_t                 upd;
    fm_pick_t                pick;
    logic                    slot_in_range;
    logic [PRD_W-1:0]        quot_prod;
    logic [Q_W-1:0]          quot1;
    logic [SLOT_FIELD_W-1:0] s1_slot;

    logic [RW-1:0]           rem_wide;
    logic [SLOT_W:0]         rem_raw;
    logic [SLOT_W:0]         rem_fix;
    logic [SLOT_FIELD_W-1:0] look_slot;
    logic                    look_used;
    logic [GEN_BITS-1:0]     ram_rd;
    logic [GEN_BITS-1:0]     gen_cur;
    logic [HP_W-1:0]         handle_wide;
    logic                    gen_we;
    logic [SLOT_W-1:0]       gen_waddr;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Capture the request transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
    end

    // Stage 1: pick a slot, update the free map, start the modulo
    assign slot_in_range = {1'b0, s1_req_reg.slot_index} < (SLOT_FIELD_W + 1)'(SLOT_COUNT);

    always_comb
    begin
        upd.alloc_en  = s1_vld_reg && (s1_req_reg.cmd == CMD_ALLOC) && pick.any_free;
        upd.free_en   = s1_vld_reg && (s1_req_reg.cmd == CMD_FREE) && slot_in_range;
        upd.free_slot = s1_req_reg.slot_index;
    end

    sha_free_map #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_free_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .pick      (pick),
        .look_slot (look_slot),
        .look_used (look_used)
    );

    assign quot_prod = PRD_W'(s1_req_reg.handle_in) * PRD_W'(RECIP);
    assign quot1     = quot_prod[PRD_W-1:K];
    assign s1_slot   = (s1_req_reg.cmd == CMD_ALLOC) ? pick.slot : s1_req_reg.slot_index;

    // Generation counters
    sha_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .clk     (clk),
        .wr_en   (gen_we),
        .wr_addr (gen_waddr),
        .wr_data (gen_cur + GEN_BITS'(1)),
        .rd_en   (upd.alloc_en),
        .rd_addr (pick.slot[SLOT_W-1:0]),
        .rd_data (ram_rd)
    );

    // Advance to stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg  <= s1_req_reg.cmd;
        s2_slot_reg <= s1_slot;
        s2_ok_reg   <= pick.any_free;
        s2_quot_reg <= quot1;
        s2_hin_reg  <= s1_req_reg.handle_in;
        s2_gvld_reg <= gen_vld_reg[pick.slot[SLOT_W-1:0]];
    end

    // Stage 2: finish the modulo with one correction step
    always_comb
    begin
        rem_wide  = RW'(s2_hin_reg) - RW'(s2_quot_reg) * RW'(SLOT_COUNT);
        rem_raw   = rem_wide[SLOT_W:0];
        rem_fix   = (rem_raw >= (SLOT_W + 1)'(SLOT_COUNT))
                    ? rem_raw - (SLOT_W + 1)'(SLOT_COUNT) : rem_raw;
        look_slot = SLOT_FIELD_W'(rem_fix[SLOT_W-1:0]);
    end

    // Stage 2: build the handle and bump the generation
    assign gen_cur     = s2_gvld_reg ? ram_rd : '0;
    assign handle_wide = HP_W'(gen_cur) * HP_W'(SLOT_COUNT) + HP_W'(s2_slot_reg);
    assign gen_we      = s2_vld_reg && (s2_cmd_reg == CMD_ALLOC) && s2_ok_reg;
    assign gen_waddr   = s2_slot_reg[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_vld_reg <= '0;
        end
        else if (gen_we)
        begin
            gen_vld_reg[gen_waddr] <= 1'b1;
        end
    end

    // Form the response transaction
    always_comb
    begin
        rsp_next = '0;
        case (s2_cmd_reg)
            CMD_ALLOC:
            begin
                if (s2_ok_reg)
                begin
                    rsp_next.status     = STATUS_OK;
                    rsp_next.slot_out   = s2_slot_reg;
                    rsp_next.handle_out = handle_wide[HANDLE_W-1:0];
                end
                else
                begin
                    rsp_next.status = STATUS_NOFREE;
                end
            end
            CMD_FREE:
            begin
                rsp_next.status   = STATUS_OK;
                rsp_next.slot_out = s2_slot_reg;
            end
            CMD_VALIDATE:
            begin
                rsp_next.status   = ((s2_hin_reg != '0) && look_used)
                                    ? STATUS_OK : STATUS_INVALID;
                rsp_next.slot_out = look_slot;
            end
            default:
            begin
                rsp_next.status = STATUS_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Assertions
    `SHA_ASSERT_LAT(a_fixed_latency, start && !busy, 3, done, "result did not follow request")
    `SHA_ASSERT_ALWAYS(a_single_update, !(upd.alloc_en && upd.free_en), "alloc and free at once")
    `SHA_ASSERT_ALWAYS(a_gen_no_hazard,
        !(gen_we && upd.alloc_en && (pick.slot[SLOT_W-1:0] == gen_waddr)),
        "generation read collides with pending write")

endmodule

>>> sim/slot_handle_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot handle allocator checker
// Watches the command and result channels, keeps its own free map and
// generation counters, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module slot_handle_allocator_checker #(
    parameter int SLOT_COUNT = sha_pkg::DEF_SLOT_COUNT,
    parameter int GEN_BITS   = sha_pkg::DEF_GEN_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  sha_pkg::req_t req,
    input  logic          done,
    input  sha_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending
);

    import sha_pkg::*;

    localparam int MAX_REPORTS = 50;

    // Shadow state: bit set means slot is free
    logic [63:0]         slot_free_map;
    logic [GEN_BITS-1:0] slot_gen [64];
    rsp_t                awaited_rsp [$];
    int                  mismatches;

    // Print one line per mismatch for the first 50, count every one
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        begin
            if (mismatches < MAX_REPORTS)
                $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
            mismatches++;
        end
    endtask

    // Apply one transaction to the shadow state and return its result
    function automatic rsp_t predict_slot_response(input req_t item);
        rsp_t        res;
        logic [63:0] avail;
        logic [63:0] handle_full;
        int          pick;
        int unsigned slot_of_handle;
        begin
            res   = '0;
            avail = slot_free_map;
            pick  = -1;
            for (int i = 63; i >= 0; i--)
                if (i >= SLOT_COUNT)
                    avail[i] = 1'b0;
            case (item.cmd)
                CMD_ALLOC:
                begin
                    for (int i = SLOT_COUNT - 1; i >= 0; i--)
                        if (avail[i])
                            pick = i;
                    if (pick < 0)
                    begin
                        res.status = STATUS_NOFREE;
                    end
                    else
                    begin
                        handle_full = 64'(slot_gen[pick]) * 64'(SLOT_COUNT) + 64'(pick);
                        res.status     = STATUS_OK;
                        res.slot_out   = SLOT_FIELD_W'(pick);
                        res.handle_out = handle_full[HANDLE_W-1:0];
                        slot_free_map[pick] = 1'b0;
                        slot_gen[pick]      = slot_gen[pick] + 1'b1;
                    end
                end
                CMD_FREE:
                begin
                    if (int'(item.slot_index) < SLOT_COUNT)
                        slot_free_map[item.slot_index] = 1'b1;
                    res.status   = STATUS_OK;
                    res.slot_out = item.slot_index;
                end
                CMD_VALIDATE:
                begin
                    slot_of_handle = int'(item.handle_in) % SLOT_COUNT;
                    res.slot_out   = SLOT_FIELD_W'(slot_of_handle);
                    if (item.handle_in != '0 && !avail[slot_of_handle])
                        res.status = STATUS_OK;
                    else
                        res.status = STATUS_INVALID;
                end
                default:
                begin
                    res.status = STATUS_INVALID;
                end
            endcase
            return res;
        end
    endfunction

    // Compare finished results, then predict newly accepted transactions
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            slot_free_map = '0;
            for (int i = 0; i < 64; i++)
            begin
                slot_gen[i] = '0;
                if (i < SLOT_COUNT)
                    slot_free_map[i] = 1'b1;
            end
            awaited_rsp.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    report_mismatch("result with nothing awaited, status", 64'(rsp.status), '0);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 64'(rsp.status), 64'(want.status));
                    if (rsp.slot_out !== want.slot_out)
                        report_mismatch("slot_out", 64'(rsp.slot_out), 64'(want.slot_out));
                    if (rsp.handle_out !== want.handle_out)
                        report_mismatch("handle_out", 64'(rsp.handle_out),
                                        64'(want.handle_out));
                end
            end
            if (start && !busy)
                awaited_rsp.push_back(predict_slot_response(req));
            fail_count <= mismatches;
            pending    <= awaited_rsp.size();
        end
    end

endmodule

>>> sim/slot_handle_allocator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot handle allocator testbench
// Drives directed and random allocate, free, validate and unused-command
// transactions with random sender gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module slot_handle_allocator_top_test;
    import sha_pkg::*;

    localparam int         SLOT_COUNT     = DEF_SLOT_COUNT;
    localparam int         GEN_BITS       = DEF_GEN_BITS;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         RANDOM_ITEMS   = 1800;
    localparam int         PHASE_ITEMS    = 600;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         DRAIN_CYCLES   = 10;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_cycles;

    slot_handle_allocator_top #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    slot_handle_allocator_checker #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Free-running clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL slot_handle_allocator_top");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Hold start for one transaction until it is taken, with random gaps ahead
    task automatic send_command(input req_t item);
        begin
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            start <= 1'b1;
            req   <= item;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    // Build a transaction with random payload; validate handles vary in shape
    function automatic req_t make_command(input logic [1:0] op);
        req_t        item;
        int unsigned shape;
        begin
            item.cmd        = op;
            item.slot_index = SLOT_FIELD_W'($urandom);
            item.handle_in  = HANDLE_W'($urandom);
            shape           = $urandom_range(7);
            if (op == CMD_VALIDATE)
            begin
                if (shape == 0)
                    item.handle_in = '0;
                else if (shape < 4)
                    item.handle_in = HANDLE_W'($urandom_range(15) * SLOT_COUNT
                                     + $urandom_range(SLOT_COUNT - 1));
            end
            return item;
        end
    endfunction

    function automatic req_t pack_command(input logic [1:0] op,
                                          input logic [SLOT_FIELD_W-1:0] slot,
                                          input logic [HANDLE_W-1:0] handle);
        req_t item;
        begin
            item.cmd        = op;
            item.slot_index = slot;
            item.handle_in  = handle;
            return item;
        end
    endfunction

    initial
    begin
        bit          fill_mode;
        int          run_left;
        int unsigned roll;
        logic [1:0]  op;

        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        idle_pct     = 25;
        fill_mode    = 1'b0;
        run_left     = 0;

        // Hold reset, release on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty map, zero handle, generation ignored, double free,
        // unused command, field extremes
        send_command(pack_command(CMD_VALIDATE, '0, '0));
        send_command(pack_command(CMD_ALLOC, '1, '1));
        send_command(pack_command(CMD_ALLOC, '0, '0));
        send_command(pack_command(CMD_VALIDATE, '0, '0));
        send_command(pack_command(CMD_VALIDATE, '0, HANDLE_W'(SLOT_COUNT)));
        send_command(pack_command(CMD_VALIDATE, '0, HANDLE_W'(1)));
        send_command(pack_command(CMD_VALIDATE, '1, HANDLE_W'(2)));
        send_command(pack_command(CMD_FREE, '0, '1));
        send_command(pack_command(CMD_FREE, '0, '0));
        send_command(pack_command(CMD_VALIDATE, '0, HANDLE_W'(SLOT_COUNT)));
        send_command(pack_command(CMD_ALLOC, '0, '0));
        send_command(pack_command(CMD_UNUSED, '1, '1));
        send_command(pack_command(CMD_UNUSED, '0, '0));
        send_command(pack_command(CMD_VALIDATE, '0, '1));
        send_command(pack_command(CMD_FREE, '1, '0));
        send_command(pack_command(CMD_ALLOC, '0, '0));
        send_command(pack_command(CMD_FREE, SLOT_FIELD_W'(1), '0));
        send_command(pack_command(CMD_FREE, SLOT_FIELD_W'(2), '0));
        send_command(pack_command(CMD_ALLOC, '0, '0));
        send_command(pack_command(CMD_VALIDATE, '0, {24'hABCDEF, 6'd1}));

        // Random: alternate fill runs (reach a full map) and drain runs
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == PHASE_ITEMS)
                idle_pct = 65;
            else if (n == 2 * PHASE_ITEMS)
                idle_pct = 0;
            if (run_left == 0)
            begin
                fill_mode = !fill_mode;
                run_left  = fill_mode ? $urandom_range(100, 250) : $urandom_range(40, 120);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 5)
                op = CMD_UNUSED;
            else if (roll < 20)
                op = CMD_VALIDATE;
            else if (roll < (fill_mode ? 35 : 85))
                op = CMD_FREE;
            else
                op = CMD_ALLOC;
            send_command(make_command(op));
        end

        // Drop start, wait for every awaited result, then let the pipe settle
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS slot_handle_allocator_top");
        else
            $display("FAIL slot_handle_allocator_top");
        $finish;
    end

endmodule
